// ===== rtl/bdd_pkg.sv =====
// package: shared types and constants of the bundle decoupling deque
package bdd_pkg;

    // fixed field widths
    localparam int DATA_W   = 64;
    localparam int OCC_W    = 5;
    localparam int MARGIN_W = 5;
    localparam int OP_W     = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_TAIL = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_HEAD = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_HEAD  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd3;

    // register map (word index)
    localparam logic REG_THRESHOLD_MARGIN = 1'b0;

    // reset value of the threshold margin
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 5'd2;

    // command transfer payload
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic              bundle_valid;
        logic [DATA_W-1:0] bundle_data;
    } cmd_t;

    // result transfer payload
    typedef struct packed {
        logic              pop_valid;
        logic [DATA_W-1:0] pop_data;
        logic              push_rejected;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
        logic              is_full;
        logic              at_threshold;
    } result_t;

endpackage

// ===== rtl/bundle_decoupling_deque_top.sv =====
// top level: ring-buffer deque for instruction bundles with apb threshold register
// A result is shown in the cycle after its command transfer.
// Throughput: one command per cycle; the slot memory has one write and one
// registered read port, and a pop reads the head entry at the command edge.
// busy stays low, the result receiver cannot stall and needs no buffering.
// Reset clears head pointer, count, result strobe, pop and reject flags, and sets margin (to 2); slot
// contents are not cleared and need no clearing pass.
module bundle_decoupling_deque_top #(
    parameter int SLOTS        = 16,
    parameter int BUNDLE_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command side
    input  logic                            start,
    output logic                            busy,
    input  bdd_pkg::cmd_t                   command,
    // result side
    output logic                            done,
    output bdd_pkg::result_t                result,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bdd_pkg::APB_AW-1:0]      paddr,
    input  logic [bdd_pkg::APB_DW-1:0]      pwdata,
    output logic [bdd_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = bdd_pkg::MARGIN_W;
    localparam int OW = bdd_pkg::OCC_W;
    localparam int DW = bdd_pkg::DATA_W;
    localparam int SW = ((CW > MW) ? CW : MW) + 1;
    localparam int TW = CW + 1;

    // state
    logic [BUNDLE_WIDTH-1:0] slot_mem [SLOTS];
    logic [BUNDLE_WIDTH-1:0] rdata_reg;
    logic [PW-1:0]           head_reg, head_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [MW-1:0]           margin_reg;
    logic                    done_reg;
    logic                    pop_valid_reg, pop_valid_next;
    logic                    rejected_reg, rejected_next;

    // memory access controls
    logic                    accept;
    logic                    wr_en;
    logic                    rd_en;
    logic [PW-1:0]           wr_addr;
    logic [TW-1:0]           tail_sum;
    logic [PW-1:0]           tail_idx;
    logic [PW-1:0]           head_dec;
    logic [PW-1:0]           head_inc;
    logic                    is_full_now;
    logic                    cfg_write;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign pready = 1'b1;

    // ring index arithmetic
    always_comb
    begin
        tail_sum = TW'(head_reg) + TW'(count_reg);
        if (tail_sum >= TW'(SLOTS))
        begin
            tail_sum = tail_sum - TW'(SLOTS);
        end
        tail_idx = tail_sum[PW-1:0];
        head_dec = (head_reg == '0) ? PW'(SLOTS - 1) : head_reg - PW'(1);
        head_inc = (head_reg == PW'(SLOTS - 1)) ? '0 : head_reg + PW'(1);
    end

    assign is_full_now = (count_reg == CW'(SLOTS));

    // command decode and next state
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        pop_valid_next = 1'b0;
        rejected_next  = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = tail_idx;
        if (accept)
        begin
            unique case (command.operation)
                bdd_pkg::OP_PUSH_TAIL:
                begin
                    if (command.bundle_valid)
                    begin
                        if (is_full_now)
                        begin
                            rejected_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = tail_idx;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                bdd_pkg::OP_PUSH_HEAD:
                begin
                    if (command.bundle_valid)
                    begin
                        if (is_full_now)
                        begin
                            rejected_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = head_dec;
                            head_next  = head_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                bdd_pkg::OP_POP_HEAD:
                begin
                    if (count_reg != '0)
                    begin
                        rd_en          = 1'b1;
                        pop_valid_next = 1'b1;
                        head_next      = head_inc;
                        count_next     = count_reg - CW'(1);
                    end
                end
                bdd_pkg::OP_CLEAR:
                begin
                    head_next  = '0;
                    count_next = '0;
                end
            endcase
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= command.bundle_data[BUNDLE_WIDTH-1:0];
        end
        if (rd_en)
        begin
            rdata_reg <= slot_mem[head_reg];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            pop_valid_reg <= 1'b0;
            rejected_reg  <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            done_reg      <= accept;
            pop_valid_reg <= pop_valid_next;
            rejected_reg  <= rejected_next;
        end
    end

    // configuration register transfer
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= bdd_pkg::MARGIN_RESET;
        end
        else if (cfg_write && (paddr[2] == bdd_pkg::REG_THRESHOLD_MARGIN))
        begin
            margin_reg <= pwdata[MW-1:0];
        end
    end

    // register read-back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == bdd_pkg::REG_THRESHOLD_MARGIN)
        begin
            prdata[MW-1:0] = margin_reg;
        end
    end

    // result assembly from registered state
    logic [DW-1:0] pop_data_ext;

    always_comb
    begin
        pop_data_ext = '0;
        if (pop_valid_reg)
        begin
            pop_data_ext[BUNDLE_WIDTH-1:0] = rdata_reg;
        end
        result.pop_valid     = pop_valid_reg;
        result.pop_data      = pop_data_ext;
        result.push_rejected = rejected_reg;
        result.occupancy     = OW'(count_reg);
        result.is_empty      = (count_reg == '0);
        result.is_full       = (count_reg == CW'(SLOTS));
        result.at_threshold  = (SW'(count_reg) + SW'(margin_reg)) >= SW'(SLOTS);
    end

    assign done = done_reg;

    // occupancy never exceeds the slot count
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("deque count above slot count");

    // a returned bundle lowers the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid_reg |-> (count_reg + CW'(1)) == $past(count_reg))
        else $error("pop did not lower the count by one");

    // a rejected push leaves a full buffer untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        rejected_reg |-> (count_reg == CW'(SLOTS)) && (head_reg == $past(head_reg)))
        else $error("rejected push changed the buffer");

    // every result strobe follows a command transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(start))
        else $error("result strobe without command transfer");

endmodule

// ===== tb/tb_bundle_decoupling_deque_top.sv =====
// testbench: bundle deque checked against its own predictor, with directed and random commands
module tb_bundle_decoupling_deque_top;
    import bdd_pkg::*;

    localparam int SLOTS_N       = 16;
    localparam int HEAD_W        = $clog2(SLOTS_N);
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int SCRIPT_ROWS   = 13;
    localparam int RANDOM_CHUNKS = 9;
    localparam int CHUNK_ITEMS   = 150;

    // word index with no register behind it
    localparam logic SPARE_REG = 1'b1;

    // results that can be read off at a glance
    localparam result_t RES_NONE   = '0;
    localparam result_t RES_EMPTY  = '{1'b0, 64'd0, 1'b0, 5'd0, 1'b1, 1'b0, 1'b0};
    localparam result_t RES_ONE    = '{1'b0, 64'd0, 1'b0, 5'd1, 1'b0, 1'b0, 1'b0};
    localparam result_t RES_FULL   = '{1'b0, 64'd0, 1'b0, 5'd16, 1'b0, 1'b1, 1'b1};
    localparam result_t RES_REJECT = '{1'b0, 64'd0, 1'b1, 5'd16, 1'b0, 1'b1, 1'b1};

    // one line of the directed script
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              valid;
        logic [DATA_W-1:0] data;
        logic [4:0]        reps;
        logic              typed;
        result_t           want;
    } stim_row_t;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    cmd_t                command = '0;
    logic                done;
    result_t             result;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // predictor state
    logic [DATA_W-1:0]   ring_slots [SLOTS_N];
    logic [HEAD_W-1:0]   ring_head  = '0;
    logic [OCC_W-1:0]    ring_count = '0;
    logic [MARGIN_W-1:0] margin     = MARGIN_RESET;
    logic                filling    = 1'b1;

    result_t             pending_results [$];
    result_t             oldest;
    stim_row_t           script [SCRIPT_ROWS];
    int                  mismatch_count = 0;
    int                  cmds_sent      = 0;
    int                  pops_seen      = 0;
    int                  rejects_seen   = 0;
    int                  fulls_seen     = 0;
    int                  margins_tried  = 0;
    int                  idle_cycles    = 0;
    int                  sender_idle_pct = 0;

    bundle_decoupling_deque_top #(
        .SLOTS        (SLOTS_N),
        .BUNDLE_WIDTH (DATA_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // deque behaviour: applies one command and returns the status after it
    function automatic result_t deque_step(input cmd_t c);
        result_t           r;
        logic [HEAD_W-1:0] slot;
        r = '0;
        case (c.operation)
            OP_PUSH_TAIL, OP_PUSH_HEAD:
            begin
                if (c.bundle_valid)
                begin
                    if (ring_count >= SLOTS_N)
                        r.push_rejected = 1'b1;
                    else
                    begin
                        if (c.operation == OP_PUSH_TAIL)
                        begin
                            slot = ring_head + ring_count[HEAD_W-1:0];
                            ring_slots[slot] = c.bundle_data;
                        end
                        else
                        begin
                            ring_head = ring_head - 1'b1;
                            ring_slots[ring_head] = c.bundle_data;
                        end
                        ring_count = ring_count + 1'b1;
                    end
                end
            end
            OP_POP_HEAD:
            begin
                if (ring_count != 0)
                begin
                    r.pop_valid = 1'b1;
                    r.pop_data  = ring_slots[ring_head];
                    ring_head   = ring_head + 1'b1;
                    ring_count  = ring_count - 1'b1;
                end
            end
            default:
            begin
                ring_count = '0;
                ring_head  = '0;
            end
        endcase
        r.occupancy    = ring_count;
        r.is_empty     = (ring_count == 0);
        r.is_full      = (ring_count == SLOTS_N);
        r.at_threshold = (int'(ring_count) + int'(margin) >= SLOTS_N);
        return r;
    endfunction

    // random command, steered to swing the occupancy between empty and full
    function automatic cmd_t random_cmd();
        cmd_t        c;
        int unsigned roll;
        int unsigned shape;
        if (ring_count == SLOTS_N && $urandom_range(99) < 30)
            filling = 1'b0;
        if (ring_count == 0 && $urandom_range(1) == 1)
            filling = 1'b1;
        roll = $urandom_range(99);
        if (filling)
            c.operation = (roll < 40) ? OP_PUSH_TAIL :
                          (roll < 75) ? OP_PUSH_HEAD :
                          (roll < 99) ? OP_POP_HEAD  : OP_CLEAR;
        else
            c.operation = (roll < 20) ? OP_PUSH_TAIL :
                          (roll < 35) ? OP_PUSH_HEAD :
                          (roll < 97) ? OP_POP_HEAD  : OP_CLEAR;
        c.bundle_valid = ($urandom_range(9) != 0);
        shape = $urandom_range(99);
        if (shape < 4)
            c.bundle_data = '1;
        else if (shape < 8)
            c.bundle_data = '0;
        else
            c.bundle_data = {$urandom, $urandom};
        return c;
    endfunction

    function automatic logic [MARGIN_W-1:0] chunk_margin(input int k);
        case (k)
            0:       return 5'd0;
            1:       return 5'd16;
            2:       return 5'd1;
            3:       return 5'd31;
            4:       return 5'd17;
            5:       return 5'd2;
            6:       return 5'd8;
            7:       return 5'd15;
            default: return 5'($urandom_range(31));
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
    endtask

    task automatic compare_result(input result_t want, input result_t got);
        if (got.pop_valid !== want.pop_valid)
            flag_mismatch("pop_valid", want.pop_valid, got.pop_valid);
        if (got.pop_data !== want.pop_data)
            flag_mismatch("pop_data", want.pop_data, got.pop_data);
        if (got.push_rejected !== want.push_rejected)
            flag_mismatch("push_rejected", want.push_rejected, got.push_rejected);
        if (got.occupancy !== want.occupancy)
            flag_mismatch("occupancy", want.occupancy, got.occupancy);
        if (got.is_empty !== want.is_empty)
            flag_mismatch("is_empty", want.is_empty, got.is_empty);
        if (got.is_full !== want.is_full)
            flag_mismatch("is_full", want.is_full, got.is_full);
        if (got.at_threshold !== want.at_threshold)
            flag_mismatch("at_threshold", want.at_threshold, got.at_threshold);
    endtask

    // one command transfer; start stays high on return
    task automatic send_cmd(input cmd_t c, input logic typed, input result_t want);
        result_t predicted;
        command <= c;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = deque_step(c);
        pending_results.push_back(typed ? want : predicted);
        cmds_sent++;
    endtask

    // random gap on the command side
    task automatic sender_gap(input int pct);
        if (pct > 0 && $urandom_range(99) < pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < pct);
        end
    endtask

    // hold off until every pending result has come, then let the pipe settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // apb setup and access, then psel and penable are dropped
    task automatic reg_access(input logic wr, input logic idx,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_margin();
        logic [APB_DW-1:0] rd;
        reg_access(1'b0, REG_THRESHOLD_MARGIN, '0, rd);
        if (rd !== {{(APB_DW-MARGIN_W){1'b0}}, margin})
            flag_mismatch("margin read-back", margin, rd);
    endtask

    task automatic set_margin(input logic [MARGIN_W-1:0] value);
        logic [APB_DW-1:0] wd;
        logic [APB_DW-1:0] rd;
        drain();
        wd = $urandom;
        wd[MARGIN_W-1:0] = value;
        reg_access(1'b1, REG_THRESHOLD_MARGIN, wd, rd);
        margin = value;
        margins_tried++;
        check_margin();
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("result with nothing pending", '0, result.occupancy);
            else
            begin
                oldest = pending_results.pop_front();
                compare_result(oldest, result);
            end
            if (result.pop_valid)
                pops_seen++;
            if (result.push_rejected)
                rejects_seen++;
            if (result.is_full)
                fulls_seen++;
        end
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("bundle_decoupling_deque_top test failed");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        stim_row_t   row;
        cmd_t        c;
        int          counted;
        logic [APB_DW-1:0] rd;

        // empty, invalid pushes, fill through a head wrap, reject, pop on full, clear
        script[0]  = '{OP_POP_HEAD,  1'b0, 64'd0,                 5'd1, 1'b1, RES_EMPTY};
        script[1]  = '{OP_PUSH_TAIL, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1, 1'b1, RES_EMPTY};
        script[2]  = '{OP_PUSH_HEAD, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1, 1'b1, RES_EMPTY};
        script[3]  = '{OP_PUSH_TAIL, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1, 1'b1, RES_ONE};
        script[4]  = '{OP_PUSH_HEAD, 1'b1, 64'h8000_0000_0000_0001, 5'd7, 1'b0, RES_NONE};
        script[5]  = '{OP_PUSH_TAIL, 1'b1, 64'h0123_4567_89AB_CDE0, 5'd8, 1'b0, RES_NONE};
        script[6]  = '{OP_PUSH_TAIL, 1'b1, 64'h5555_5555_5555_5555, 5'd1, 1'b1, RES_REJECT};
        script[7]  = '{OP_PUSH_HEAD, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 5'd1, 1'b1, RES_REJECT};
        script[8]  = '{OP_PUSH_TAIL, 1'b0, 64'h5555_5555_5555_5555, 5'd1, 1'b1, RES_FULL};
        script[9]  = '{OP_POP_HEAD,  1'b0, 64'd0,                 5'd1, 1'b0, RES_NONE};
        script[10] = '{OP_PUSH_HEAD, 1'b1, 64'd0,                 5'd1, 1'b0, RES_NONE};
        script[11] = '{OP_POP_HEAD,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1, 1'b0, RES_NONE};
        script[12] = '{OP_CLEAR,     1'b0, 64'd0,                 5'd1, 1'b1, RES_EMPTY};

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_margin();

        // directed script at the reset margin
        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            row = script[i];
            for (int r = 0; r < row.reps; r++)
            begin
                c.operation    = row.op;
                c.bundle_valid = row.valid;
                c.bundle_data  = row.data + r;
                send_cmd(c, row.typed, row.want);
            end
        end

        // random chunks, one margin each; sender idling sparse, busy, then none
        for (int k = 0; k < RANDOM_CHUNKS; k++)
        begin
            set_margin(chunk_margin(k));
            if (k == 4)
            begin
                reg_access(1'b1, SPARE_REG, $urandom, rd);
                check_margin();
            end
            sender_idle_pct = (k < 3) ? 12 : (k < 6) ? 73 : 0;
            counted = 0;
            while (counted < CHUNK_ITEMS)
            begin
                c = random_cmd();
                send_cmd(c, 1'b0, RES_NONE);
                if (!((c.operation == OP_PUSH_TAIL || c.operation == OP_PUSH_HEAD)
                      && !c.bundle_valid))
                    counted++;
                if ($urandom_range(149) == 0)
                    drain();
                else
                    sender_gap(sender_idle_pct);
            end
        end

        // wind down
        drain();
        repeat (2) @(posedge clk);
        if (pending_results.size() != 0)
            flag_mismatch("results never delivered", '0, pending_results.size());

        $display("covered %0d commands: %0d pops with data, %0d rejected pushes, %0d full",
                 cmds_sent, pops_seen, rejects_seen, fulls_seen);
        $display("margins written %0d times, including 0, 1, 16, 17 and 31; %0d mismatches",
                 margins_tried, mismatch_count);
        if (mismatch_count == 0)
            $display("bundle_decoupling_deque_top test passed");
        else
            $display("bundle_decoupling_deque_top test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bdd_pkg.sv
rtl/bundle_decoupling_deque_top.sv
tb/tb_bundle_decoupling_deque_top.sv
